@@ rtl/core/sbph_pkg.sv @@
package sbph_pkg;

    localparam int MAX_BANDS_DEF = 64;
    localparam int BIN_COUNT_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CMDQ_DEPTH = 4;
    localparam int SCAN_W     = 9;
    localparam int LN_W       = 19;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_DECAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY = 3'd4;

    localparam logic [6:0]  BAND_COUNT_RST = 7'd32;
    localparam logic [7:0]  BAR_ROWS_RST   = 8'd50;
    localparam logic [15:0] LOG_GAIN_RST   = 16'd1154;
    localparam logic [15:0] BAR_DECAY_RST  = 16'd1024;
    localparam logic [15:0] PEAK_DECAY_RST = 16'd171;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_BIN  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  index;
        logic [7:0]  edge_req;
        logic [14:0] left_bin;
        logic [14:0] right_bin;
        logic        frame_end;
    } sbph_in_t;

    typedef struct packed {
        logic [5:0] band;
        logic [7:0] left_bar;
        logic [7:0] right_bar;
        logic [7:0] left_peak;
        logic [7:0] right_peak;
        logic       last;
    } sbph_out_t;

    typedef struct packed {
        logic       wr_edge;
        logic       wr_bin;
        logic       frame;
        logic [7:0] addr;
        logic [7:0] edge_val;
        logic [7:0] left;
        logic [7:0] right;
    } sbph_cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LO,
        B_HI,
        B_RANGE,
        B_SCAN,
        B_DRAIN,
        B_LN,
        B_MUL,
        B_CLAMP,
        B_LVL_L,
        B_LVL_R,
        B_OUT
    } sbph_state_t;

    typedef logic [255:0][LN_W-1:0] ln_table_t;

    // ln(y) in Q.16 via log2 by repeated squaring, times ln 2
    function automatic ln_table_t build_ln();
        ln_table_t   t;
        logic [63:0] m;
        logic [63:0] l2;
        int          e;
        t = '0;
        for (int y = 1; y < 256; y++) begin
            e = 0;
            for (int b = 1; b < 8; b++) begin
                if ((y >> b) != 0) e = b;
            end
            m  = (64'(y) << 16) >> e;
            l2 = 64'(e) << 16;
            for (int b = 0; b < 16; b++) begin
                m = (m * m) >> 16;
                if (m >= 64'h20000) begin
                    m  = m >> 1;
                    l2 = l2 | (64'd1 << (15 - b));
                end
            end
            t[y] = LN_W'((l2 * 64'd45426) >> 16);
        end
        return t;
    endfunction

    localparam ln_table_t LN_TABLE = build_ln();

endpackage

@@ rtl/core/sbph_front.sv @@
module sbph_front #(
    parameter int MAX_BANDS = sbph_pkg::MAX_BANDS_DEF,
    parameter int BIN_COUNT = sbph_pkg::BIN_COUNT_DEF
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  sbph_pkg::sbph_in_t  s_data,
    input  logic                q_full,
    output logic                q_push,
    output sbph_pkg::sbph_cmd_t q_cmd
);

    logic edge_ok;
    logic bin_ok;

    always_comb begin
        edge_ok = (s_data.op == sbph_pkg::OP_EDGE) && (9'(s_data.index) <= 9'(MAX_BANDS));
        bin_ok  = (s_data.op == sbph_pkg::OP_BIN) && (11'(s_data.index) < 11'(BIN_COUNT));

        q_cmd.wr_edge  = edge_ok;
        q_cmd.wr_bin   = bin_ok;
        // a bin item outside the store still ends the frame
        q_cmd.frame    = (s_data.op == sbph_pkg::OP_BIN) && s_data.frame_end;
        q_cmd.addr     = s_data.index;
        q_cmd.edge_val = s_data.edge_req;
        q_cmd.left     = s_data.left_bin[14:7];
        q_cmd.right    = s_data.right_bin[14:7];
    end

    assign s_ready = !q_full;
    // items that change nothing are taken and dropped here
    assign q_push  = s_valid && !q_full && (q_cmd.wr_edge || q_cmd.wr_bin || q_cmd.frame);

endmodule

@@ rtl/core/sbph_cmdq.sv @@
module sbph_cmdq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sbph_pkg::sbph_cmd_t push_cmd,
    output logic                full,
    output logic                valid,
    output sbph_pkg::sbph_cmd_t head,
    input  logic                pop
);

    localparam int QAW = $clog2(sbph_pkg::CMDQ_DEPTH);

    sbph_pkg::sbph_cmd_t mem [sbph_pkg::CMDQ_DEPTH];
    logic [QAW-1:0]      wr_ptr_reg;
    logic [QAW-1:0]      rd_ptr_reg;
    logic [QAW:0]        count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QAW + 1)'(sbph_pkg::CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QAW + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QAW + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/core/sbph_back.sv @@
module sbph_back #(
    parameter int MAX_BANDS = sbph_pkg::MAX_BANDS_DEF,
    parameter int BIN_COUNT = sbph_pkg::BIN_COUNT_DEF,
    parameter int FRAC_BITS = sbph_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sbph_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbph_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                q_valid,
    input  sbph_pkg::sbph_cmd_t                 q_head,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sbph_pkg::sbph_out_t                 m_data
);

    localparam int BAND_W  = $clog2(MAX_BANDS + 1);
    localparam int EDGE_AW = BAND_W;
    localparam int LVL_N   = 2 * MAX_BANDS;
    localparam int LVL_AW  = $clog2(LVL_N);
    localparam int BIN_AW  = $clog2(BIN_COUNT);
    localparam int LW      = 8 + FRAC_BITS;
    localparam int UPSH    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int DNSH    = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
    localparam int DW      = 16 + UPSH;
    localparam int CW      = (DW > LW) ? DW : LW;
    localparam int PROD_W  = sbph_pkg::LN_W + 16;
    localparam int SW      = sbph_pkg::SCAN_W;
    localparam logic [SW-1:0] BIN_LIM = (BIN_COUNT >= 256) ? SW'(256) : SW'(BIN_COUNT);

    // level update: fall by decay, floor at zero, then follow the magnitude
    function automatic logic [LW-1:0] fall(input logic [LW-1:0] level,
                                           input logic [15:0] decay,
                                           input logic [7:0] mag);
        logic [CW-1:0] d;
        logic [CW-1:0] lv;
        logic [LW-1:0] v;
        logic [LW-1:0] m;
        d  = (CW'(decay) << UPSH) >> DNSH;
        lv = CW'(level);
        v  = (lv > d) ? LW'(lv - d) : '0;
        m  = {mag, {FRAC_BITS{1'b0}}};
        return (m > v) ? m : v;
    endfunction

    // configuration
    logic [6:0]  band_count_reg;
    logic [7:0]  bar_rows_reg;
    logic [15:0] log_gain_reg;
    logic [15:0] bar_decay_reg;
    logic [15:0] peak_decay_reg;
    logic        lvl_clear;

    // sequencer
    sbph_pkg::sbph_state_t state_reg;
    sbph_pkg::sbph_state_t state_next;
    logic [BAND_W-1:0]     band_reg;
    logic [BAND_W-1:0]     n_reg;
    logic [BAND_W-1:0]     n_cur;
    logic                  last_band;
    logic                  out_load;
    logic                  rd_v_reg;

    // storage
    logic [7:0]        edge_mem [MAX_BANDS + 1];
    logic [7:0]        bin_l_mem [BIN_COUNT];
    logic [7:0]        bin_r_mem [BIN_COUNT];
    logic [2*LW-1:0]   lvl_mem [LVL_N];
    logic [LVL_N-1:0]  lvl_valid_reg;

    logic [7:0]        edge_q_reg;
    logic [7:0]        bin_l_q_reg;
    logic [7:0]        bin_r_q_reg;
    logic [2*LW-1:0]   lvl_q_reg;
    logic              lvl_ok_reg;
    logic [2*LW-1:0]   lvl_rd;

    logic [EDGE_AW-1:0] edge_raddr;
    logic [LVL_AW-1:0]  lvl_raddr;
    logic [LVL_AW-1:0]  lvl_waddr;
    logic               lvl_we;
    logic [LVL_AW-1:0]  entry_i;
    logic [LVL_AW-1:0]  entry_j;
    logic [BAND_W:0]    j_full;

    // datapath
    logic [7:0]        lo_reg;
    logic [7:0]        hi_reg;
    logic [SW-1:0]     scan_k_reg;
    logic [SW-1:0]     scan_stop_reg;
    logic [SW-1:0]     scan_start;
    logic [SW-1:0]     scan_lim;
    logic [SW-1:0]     scan_stop;
    logic              scan_empty;
    logic              scan_done;
    logic [7:0]        y_l_reg;
    logic [7:0]        y_r_reg;
    logic [sbph_pkg::LN_W-1:0] ln_l_reg;
    logic [sbph_pkg::LN_W-1:0] ln_r_reg;
    logic [PROD_W-1:0] prod_l_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-25:0] mag_raw_l;
    logic [PROD_W-25:0] mag_raw_r;
    logic [7:0]        mag_l_reg;
    logic [7:0]        mag_r_reg;
    logic [LW-1:0]     new_bar;
    logic [LW-1:0]     new_peak;
    logic [7:0]        res_lbar_reg;
    logic [7:0]        res_lpeak_reg;
    logic [7:0]        res_rbar_reg;
    logic [7:0]        res_rpeak_reg;
    logic              out_valid_reg;
    sbph_pkg::sbph_out_t out_data_reg;

    assign n_cur     = (int'(band_count_reg) > MAX_BANDS) ? BAND_W'(MAX_BANDS)
                                                          : BAND_W'(band_count_reg);
    assign last_band = ((BAND_W + 1)'(band_reg) + (BAND_W + 1)'(1)) == (BAND_W + 1)'(n_reg);
    assign lvl_clear = cfg_we &&
        (((cfg_index == sbph_pkg::CFG_BAND_COUNT) && (cfg_wdata[6:0] != band_count_reg)) ||
         ((cfg_index == sbph_pkg::CFG_BAR_ROWS) && (cfg_wdata[7:0] != bar_rows_reg)));

    // right channel levels sit at the mirrored entry
    assign j_full  = ((BAND_W + 1)'(n_reg) << 1) - (BAND_W + 1)'(1) - (BAND_W + 1)'(band_reg);
    assign entry_i = LVL_AW'(band_reg);
    assign entry_j = LVL_AW'(j_full);

    // range of the current band
    always_comb begin
        if (lo_reg == hi_reg) begin
            scan_start = SW'(band_reg);
            scan_lim   = SW'(band_reg) + SW'(1);
        end else begin
            scan_start = SW'(lo_reg);
            scan_lim   = SW'(hi_reg);
        end
        scan_stop  = (scan_lim < BIN_LIM) ? scan_lim : BIN_LIM;
        scan_empty = (scan_start >= scan_stop);
        scan_done  = ((scan_k_reg + SW'(1)) == scan_stop_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbph_pkg::B_IDLE: begin
                if (q_valid && q_head.frame && (n_cur != '0)) state_next = sbph_pkg::B_LO;
            end
            sbph_pkg::B_LO:    state_next = sbph_pkg::B_HI;
            sbph_pkg::B_HI:    state_next = sbph_pkg::B_RANGE;
            sbph_pkg::B_RANGE: state_next = scan_empty ? sbph_pkg::B_LN : sbph_pkg::B_SCAN;
            sbph_pkg::B_SCAN: begin
                if (scan_done) state_next = sbph_pkg::B_DRAIN;
            end
            sbph_pkg::B_DRAIN: state_next = sbph_pkg::B_LN;
            sbph_pkg::B_LN:    state_next = sbph_pkg::B_MUL;
            sbph_pkg::B_MUL:   state_next = sbph_pkg::B_CLAMP;
            sbph_pkg::B_CLAMP: state_next = sbph_pkg::B_LVL_L;
            sbph_pkg::B_LVL_L: state_next = sbph_pkg::B_LVL_R;
            sbph_pkg::B_LVL_R: state_next = sbph_pkg::B_OUT;
            sbph_pkg::B_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = last_band ? sbph_pkg::B_IDLE : sbph_pkg::B_HI;
                end
            end
            default: state_next = sbph_pkg::B_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_pop      = 1'b0;
        out_load   = 1'b0;
        lvl_we     = 1'b0;
        lvl_waddr  = entry_i;
        lvl_raddr  = entry_i;
        edge_raddr = EDGE_AW'((BAND_W + 1)'(band_reg) + (BAND_W + 1)'(1));
        case (state_reg)
            sbph_pkg::B_IDLE: begin
                q_pop      = q_valid;
                edge_raddr = '0;
            end
            sbph_pkg::B_LVL_L: begin
                lvl_we    = 1'b1;
                lvl_waddr = entry_i;
                lvl_raddr = entry_j;
            end
            sbph_pkg::B_LVL_R: begin
                lvl_we    = 1'b1;
                lvl_waddr = entry_j;
            end
            sbph_pkg::B_OUT: begin
                out_load   = !out_valid_reg || m_ready;
                // fetch the upper edge of the next band
                edge_raddr = EDGE_AW'((BAND_W + 1)'(band_reg) + (BAND_W + 1)'(2));
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbph_pkg::B_IDLE;
            band_reg       <= '0;
            n_reg          <= '0;
            rd_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            lvl_valid_reg  <= '0;
            band_count_reg <= sbph_pkg::BAND_COUNT_RST;
            bar_rows_reg   <= sbph_pkg::BAR_ROWS_RST;
            log_gain_reg   <= sbph_pkg::LOG_GAIN_RST;
            bar_decay_reg  <= sbph_pkg::BAR_DECAY_RST;
            peak_decay_reg <= sbph_pkg::PEAK_DECAY_RST;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == sbph_pkg::B_SCAN);

            if (state_reg == sbph_pkg::B_IDLE) begin
                band_reg <= '0;
                n_reg    <= n_cur;
            end else if (out_load && !last_band) begin
                band_reg <= band_reg + BAND_W'(1);
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (lvl_clear) begin
                lvl_valid_reg <= '0;
            end else if (lvl_we) begin
                lvl_valid_reg[lvl_waddr] <= 1'b1;
            end

            if (cfg_we) begin
                case (cfg_index)
                    sbph_pkg::CFG_BAND_COUNT: band_count_reg <= cfg_wdata[6:0];
                    sbph_pkg::CFG_BAR_ROWS:   bar_rows_reg   <= cfg_wdata[7:0];
                    sbph_pkg::CFG_LOG_GAIN:   log_gain_reg   <= cfg_wdata;
                    sbph_pkg::CFG_BAR_DECAY:  bar_decay_reg  <= cfg_wdata;
                    sbph_pkg::CFG_PEAK_DECAY: peak_decay_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (q_pop && q_head.wr_edge) edge_mem[EDGE_AW'(q_head.addr)] <= q_head.edge_val;
        edge_q_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.wr_bin) begin
            bin_l_mem[BIN_AW'(q_head.addr)] <= q_head.left;
            bin_r_mem[BIN_AW'(q_head.addr)] <= q_head.right;
        end
        bin_l_q_reg <= bin_l_mem[BIN_AW'(scan_k_reg)];
        bin_r_q_reg <= bin_r_mem[BIN_AW'(scan_k_reg)];
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) lvl_mem[lvl_waddr] <= {new_bar, new_peak};
        lvl_q_reg  <= lvl_mem[lvl_raddr];
        lvl_ok_reg <= lvl_valid_reg[lvl_raddr];
    end

    assign lvl_rd = lvl_ok_reg ? lvl_q_reg : '0;

    always_comb begin
        if (state_reg == sbph_pkg::B_LVL_L) begin
            new_bar  = fall(lvl_rd[2*LW-1:LW], bar_decay_reg, mag_l_reg);
            new_peak = fall(lvl_rd[LW-1:0], peak_decay_reg, mag_l_reg);
        end else begin
            new_bar  = fall(lvl_rd[2*LW-1:LW], bar_decay_reg, mag_r_reg);
            new_peak = fall(lvl_rd[LW-1:0], peak_decay_reg, mag_r_reg);
        end
    end

    assign mag_raw_l = prod_l_reg[PROD_W-1:24];
    assign mag_raw_r = prod_r_reg[PROD_W-1:24];

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            sbph_pkg::B_LO:    lo_reg <= edge_q_reg;
            sbph_pkg::B_HI:    hi_reg <= edge_q_reg;
            sbph_pkg::B_RANGE: begin
                scan_k_reg    <= scan_start;
                scan_stop_reg <= scan_stop;
            end
            sbph_pkg::B_SCAN:  scan_k_reg <= scan_k_reg + SW'(1);
            sbph_pkg::B_LN: begin
                ln_l_reg <= sbph_pkg::LN_TABLE[y_l_reg];
                ln_r_reg <= sbph_pkg::LN_TABLE[y_r_reg];
            end
            sbph_pkg::B_MUL: begin
                prod_l_reg <= PROD_W'(ln_l_reg) * PROD_W'(log_gain_reg);
                prod_r_reg <= PROD_W'(ln_r_reg) * PROD_W'(log_gain_reg);
            end
            sbph_pkg::B_CLAMP: begin
                mag_l_reg <= (mag_raw_l > (PROD_W - 24)'(bar_rows_reg)) ? bar_rows_reg
                                                                         : mag_raw_l[7:0];
                mag_r_reg <= (mag_raw_r > (PROD_W - 24)'(bar_rows_reg)) ? bar_rows_reg
                                                                         : mag_raw_r[7:0];
            end
            sbph_pkg::B_LVL_L: begin
                res_lbar_reg  <= new_bar[LW-1:FRAC_BITS];
                res_lpeak_reg <= new_peak[LW-1:FRAC_BITS];
            end
            sbph_pkg::B_LVL_R: begin
                res_rbar_reg  <= new_bar[LW-1:FRAC_BITS];
                res_rpeak_reg <= new_peak[LW-1:FRAC_BITS];
            end
            sbph_pkg::B_OUT: begin
                if (out_load && !last_band) lo_reg <= hi_reg;
            end
            default: begin
            end
        endcase

        // running maximum over the bins read back
        if (state_reg == sbph_pkg::B_RANGE) begin
            y_l_reg <= '0;
            y_r_reg <= '0;
        end else if (rd_v_reg) begin
            if (bin_l_q_reg > y_l_reg) y_l_reg <= bin_l_q_reg;
            if (bin_r_q_reg > y_r_reg) y_r_reg <= bin_r_q_reg;
        end

        if (out_load) begin
            out_data_reg.band       <= 6'(band_reg);
            out_data_reg.left_bar   <= res_lbar_reg;
            out_data_reg.right_bar  <= res_rbar_reg;
            out_data_reg.left_peak  <= res_lpeak_reg;
            out_data_reg.right_peak <= res_rpeak_reg;
            out_data_reg.last       <= last_band;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/core/spectrum_bar_peak_hold_top.sv @@
// Stereo spectrum bar engine with bar decay and peak hold.
// s_ channel (valid/ready) carries items: op 0 writes one band edge entry,
// op 1 stores a left/right bin pair (top 8 of 15 bits); frame_end on a bin
// item runs the band update for that frame.
// m_ channel (valid/ready) returns one transaction per band in use, bands in
// ascending order, last set on the final band. cfg_we/cfg_index/cfg_wdata
// write one of five registers by cfg_index; write them only while idle.
// Edge and bin items are taken one per cycle, unless the queue is full,
// through a 4-entry command queue; the back end executes one command per
// cycle when it is idle. Per band, the range is scanned one bin a cycle
// through the single read port of the bin memory, then log table, gain
// multiply, clamp and two level read-modify-writes run in sequence; an
// empty range skips the scan.
// While a frame runs, later items wait in the queue; s_ready drops when full.
// If the receiver stalls, the sequencer holds at the output register and
// resumes when the result is taken. Reset restores register defaults and
// zeroes all bar and peak levels; edge and bin stores are undefined.
module spectrum_bar_peak_hold_top #(
    parameter int MAX_BANDS = sbph_pkg::MAX_BANDS_DEF,
    parameter int BIN_COUNT = sbph_pkg::BIN_COUNT_DEF,
    parameter int FRAC_BITS = sbph_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbph_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sbph_pkg::sbph_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sbph_pkg::sbph_out_t            m_data
);

    logic                q_push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    sbph_pkg::sbph_cmd_t q_cmd;
    sbph_pkg::sbph_cmd_t q_head;

    sbph_front #(
        .MAX_BANDS (MAX_BANDS),
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    sbph_cmdq u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    sbph_back #(
        .MAX_BANDS (MAX_BANDS),
        .BIN_COUNT (BIN_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> q_valid)
        else $error("pushed command not visible at queue head");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

@@ bench/tb_spectrum_bar_peak_hold_top.sv @@
module tb_spectrum_bar_peak_hold_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbph_pkg::*;

    localparam int NBANDS     = MAX_BANDS_DEF;
    localparam int NBINS      = BIN_COUNT_DEF;
    localparam int SETTLE     = 64;
    localparam int LIMIT      = 4_000_000;
    localparam int PHASE_LEN  = 22;
    localparam int PHASES     = 5;
    localparam int PRED       = -1;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        int          reg_val;
        logic        op;
        int          idx;
        int          edge_v;
        int          lbin;
        int          rbin;
        bit          fe;
        int          exp_bar;
        int          exp_peak;
    } step_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    sbph_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    sbph_out_t            m_data;

    // shadow of the block: stores, levels and registers
    bit [7:0]    left_store [NBINS];
    bit [7:0]    right_store [NBINS];
    bit [7:0]    edge_tab [NBANDS+1];
    int unsigned bar_q [2*NBANDS];
    int unsigned peak_q [2*NBANDS];
    int unsigned ln_q16 [256];
    bit [6:0]    n_bands;
    bit [7:0]    rows;
    bit [15:0]   gain;
    bit [15:0]   bar_fall;
    bit [15:0]   peak_fall;

    sbph_out_t pending_bars [$];
    step_t     script [$];

    bit calm;
    int cycles = 0;
    int errors = 0;
    int items_sent;
    int frames_seen;
    int bars_checked = 0;
    int reg_writes;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    spectrum_bar_peak_hold_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // natural log in Q.16: log2 by repeated squaring, then times ln 2
    initial begin
        longint unsigned m;
        longint unsigned l2;
        int              e;
        ln_q16[0] = 0;
        for (int y = 1; y < 256; y++) begin
            e = 0;
            while ((y >> (e + 1)) != 0) e++;
            m  = (longint'(y) << 16) >> e;
            l2 = longint'(e) << 16;
            for (int b = 0; b < 16; b++) begin
                m = (m * m) >> 16;
                if (m >= (64'd2 << 16)) begin
                    m  = m >> 1;
                    l2 = l2 | (64'd1 << (15 - b));
                end
            end
            ln_q16[y] = 32'((l2 * 64'd45426) >> 16);
        end
    end

    function automatic int unsigned band_mag(bit [7:0] y);
        longint unsigned p;
        p = (longint'(ln_q16[y]) * longint'(gain)) >> 24;
        return (p > rows) ? rows : 32'(p);
    endfunction

    function automatic int unsigned next_level(int unsigned lvl, bit [15:0] fall,
                                               int unsigned mag);
        int unsigned v;
        v = (lvl > fall) ? lvl - fall : 0;
        return ((mag << 8) > v) ? (mag << 8) : v;
    endfunction

    function automatic void clear_levels();
        foreach (bar_q[i]) begin
            bar_q[i]  = 0;
            peak_q[i] = 0;
        end
    endfunction

    function automatic void load_reg(logic [2:0] r, bit [15:0] v);
        case (r)
            CFG_BAND_COUNT: begin
                if (v[6:0] != n_bands) clear_levels();
                n_bands = v[6:0];
            end
            CFG_BAR_ROWS: begin
                if (v[7:0] != rows) clear_levels();
                rows = v[7:0];
            end
            CFG_LOG_GAIN:   gain = v;
            CFG_BAR_DECAY:  bar_fall = v;
            CFG_PEAK_DECAY: peak_fall = v;
            default: ;
        endcase
    endfunction

    // store one transaction and, on frame end, work out every band result
    function automatic void update_bands(sbph_in_t it, int eb, int ep);
        int          n;
        int          j;
        int          lo;
        int          hi;
        bit [7:0]    yl;
        bit [7:0]    yr;
        int unsigned ml;
        int unsigned mr;
        sbph_out_t   r;
        if (it.op == OP_EDGE) begin
            if (it.index <= NBANDS) edge_tab[it.index] = it.edge_req;
            return;
        end
        left_store[it.index]  = it.left_bin[14:7];
        right_store[it.index] = it.right_bin[14:7];
        if (!it.frame_end) return;
        frames_seen++;
        n = (n_bands > NBANDS) ? NBANDS : n_bands;
        for (int i = 0; i < n; i++) begin
            j  = 2 * n - 1 - i;
            lo = edge_tab[i];
            hi = edge_tab[i+1];
            yl = 0;
            yr = 0;
            // equal edges fall back to the band's own bin
            if (lo == hi) begin
                yl = left_store[i];
                yr = right_store[i];
            end
            for (int k = lo; k < hi && k < NBINS; k++) begin
                if (left_store[k] > yl) yl = left_store[k];
                if (right_store[k] > yr) yr = right_store[k];
            end
            ml = band_mag(yl);
            mr = band_mag(yr);
            bar_q[i]  = next_level(bar_q[i], bar_fall, ml);
            bar_q[j]  = next_level(bar_q[j], bar_fall, mr);
            peak_q[i] = next_level(peak_q[i], peak_fall, ml);
            peak_q[j] = next_level(peak_q[j], peak_fall, mr);
            r.band       = 6'(i);
            r.left_bar   = 8'(bar_q[i] >> 8);
            r.right_bar  = 8'(bar_q[j] >> 8);
            r.left_peak  = 8'(peak_q[i] >> 8);
            r.right_peak = 8'(peak_q[j] >> 8);
            r.last       = (i + 1 == n);
            if (eb != PRED) begin
                r.left_bar  = 8'(eb);
                r.right_bar = 8'(eb);
            end
            if (ep != PRED) begin
                r.left_peak  = 8'(ep);
                r.right_peak = 8'(ep);
            end
            pending_bars.push_back(r);
        end
    endfunction

    function automatic step_t reg_row(logic [2:0] r, int v);
        step_t s;
        s = '{default: 0};
        s.is_reg  = 1'b1;
        s.reg_idx = r;
        s.reg_val = v;
        return s;
    endfunction

    function automatic step_t item_row(logic op, int idx, int ev, int l, int r,
                                       bit fe, int eb, int ep);
        step_t s;
        s = '{default: 0};
        s.op       = op;
        s.idx      = idx;
        s.edge_v   = ev;
        s.lbin     = l;
        s.rbin     = r;
        s.fe       = fe;
        s.exp_bar  = eb;
        s.exp_peak = ep;
        return s;
    endfunction

    function automatic logic [14:0] pick_bin();
        case ($urandom_range(0, 5))
            0:       return 15'd0;
            1:       return 15'h7fff;
            2:       return 15'($urandom_range(0, 127));
            3:       return 15'($urandom_range(128, 1023));
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic int pick_reg(int lo, int hi, int mid_hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, mid_hi);
        endcase
    endfunction

    task automatic report(string what);
        errors++;
        if (errors <= 30) $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(sbph_in_t it, int eb, int ep);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        update_bands(it, eb, ep);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_bars.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] r, int v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= 16'(v);
        @(posedge aclk);
        load_reg(r, 16'(v));
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // receiver: random stall bursts, none once the run turns calm
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                stall_left = 0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        sbph_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bars.size() == 0) begin
                report($sformatf("band %0d result with nothing pending", m_data.band));
            end else begin
                want = pending_bars.pop_front();
                bars_checked++;
                if (m_data.band !== want.band)
                    report($sformatf("band got %0d want %0d", m_data.band, want.band));
                if (m_data.left_bar !== want.left_bar)
                    report($sformatf("band %0d left_bar got %0d want %0d",
                                     want.band, m_data.left_bar, want.left_bar));
                if (m_data.right_bar !== want.right_bar)
                    report($sformatf("band %0d right_bar got %0d want %0d",
                                     want.band, m_data.right_bar, want.right_bar));
                if (m_data.left_peak !== want.left_peak)
                    report($sformatf("band %0d left_peak got %0d want %0d",
                                     want.band, m_data.left_peak, want.left_peak));
                if (m_data.right_peak !== want.right_peak)
                    report($sformatf("band %0d right_peak got %0d want %0d",
                                     want.band, m_data.right_peak, want.right_peak));
                if (m_data.last !== want.last)
                    report($sformatf("band %0d last got %0d want %0d",
                                     want.band, m_data.last, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout with %0d results still pending", pending_bars.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        sbph_in_t it;
        int       ev;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        calm      = 1'b0;
        items_sent   = 0;
        frames_seen  = 0;
        reg_writes   = 0;
        n_bands   = BAND_COUNT_RST;
        rows      = BAR_ROWS_RST;
        gain      = LOG_GAIN_RST;
        bar_fall  = BAR_DECAY_RST;
        peak_fall = PEAK_DECAY_RST;
        clear_levels();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill the edge table with 4-bin bands, the last of 3 bins, and every bin
        // with zero, so no frame ever reads an unwritten entry
        for (int e = 0; e <= NBANDS; e++) begin
            it = '0;
            it.op       = OP_EDGE;
            it.index    = 8'(e);
            it.edge_req = (e < NBANDS) ? 8'(4 * e) : 8'd255;
            send_item(it, PRED, PRED);
        end
        for (int b = 0; b < NBINS; b++) begin
            it = '0;
            it.op    = OP_BIN;
            it.index = 8'(b);
            send_item(it, PRED, PRED);
        end

        script = '{
            // all-zero frame with reset levels
            item_row(OP_BIN, 0, 0, 0, 0, 1, 0, 0),
            reg_row(CFG_BAND_COUNT, 1),
            reg_row(CFG_BAR_ROWS, 255),
            reg_row(CFG_LOG_GAIN, 65535),
            reg_row(CFG_BAR_DECAY, 65535),
            reg_row(CFG_PEAK_DECAY, 0),
            // full scale clamps at bar_rows, then bar drops and peak holds
            item_row(OP_BIN, 0, 0, 32767, 32767, 1, 255, 255),
            item_row(OP_BIN, 0, 0, 0, 0, 1, 0, 255),
            // equal edges: band 0 reads bin 0, not the loud bin 1
            item_row(OP_EDGE, 1, 0, 0, 0, 0, PRED, PRED),
            item_row(OP_BIN, 1, 0, 32767, 32767, 0, PRED, PRED),
            item_row(OP_BIN, 0, 0, 128, 255, 1, 0, 255),
            // lower edge above upper edge gives zero
            item_row(OP_EDGE, 0, 5, 0, 0, 0, PRED, PRED),
            item_row(OP_BIN, 5, 0, 32767, 4660, 1, 0, 255),
            // edge writes past the table and edge items with frame_end
            item_row(OP_EDGE, 65, 77, 0, 0, 0, PRED, PRED),
            item_row(OP_EDGE, 255, 255, 32767, 32767, 1, PRED, PRED),
            // too many bands, zero gain
            reg_row(CFG_BAND_COUNT, 127),
            reg_row(CFG_LOG_GAIN, 0),
            item_row(OP_BIN, 255, 0, 32767, 32767, 1, 0, 0),
            reg_row(CFG_BAR_ROWS, 1),
            reg_row(CFG_LOG_GAIN, 65535),
            item_row(OP_EDGE, 0, 0, 0, 0, 0, PRED, PRED),
            item_row(OP_EDGE, 64, 255, 0, 0, 0, PRED, PRED),
            item_row(OP_BIN, 254, 0, 32767, 0, 1, PRED, PRED),
            reg_row(CFG_BAR_DECAY, 0),
            reg_row(CFG_PEAK_DECAY, 65535),
            item_row(OP_BIN, 3, 0, 32767, 32767, 1, PRED, PRED),
            item_row(OP_BIN, 3, 0, 0, 0, 1, PRED, PRED),
            // no bands in use: frame gives nothing
            reg_row(CFG_BAND_COUNT, 0),
            item_row(OP_BIN, 7, 0, 32767, 32767, 1, PRED, PRED)
        };

        foreach (script[s]) begin
            if (script[s].is_reg) begin
                wait_quiet();
                write_reg(script[s].reg_idx, script[s].reg_val);
            end else begin
                it.op        = script[s].op;
                it.index     = 8'(script[s].idx);
                it.edge_req  = 8'(script[s].edge_v);
                it.left_bin  = 15'(script[s].lbin);
                it.right_bin = 15'(script[s].rbin);
                it.frame_end = script[s].fe;
                send_item(it, script[s].exp_bar, script[s].exp_peak);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            calm = (ph == PHASES - 1);
            write_reg(CFG_BAND_COUNT, pick_reg(1, NBANDS, NBANDS));
            write_reg(CFG_BAR_ROWS, pick_reg(1, 255, 255));
            write_reg(CFG_LOG_GAIN, pick_reg(0, 65535, 8191));
            write_reg(CFG_BAR_DECAY, pick_reg(0, 65535, 2047));
            write_reg(CFG_PEAK_DECAY, pick_reg(0, 65535, 2047));
            repeat (PHASE_LEN) begin
                it.left_bin  = pick_bin();
                it.right_bin = pick_bin();
                if ($urandom_range(0, 9) == 0) begin
                    it.op        = OP_EDGE;
                    it.frame_end = 1'($urandom);
                    it.index     = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(0, 64));
                    // mostly short rising bands, now and then anything
                    ev = 4 * it.index + $urandom_range(0, 6) - 1;
                    if (ev < 0) ev = 0;
                    if (ev > 255) ev = 255;
                    it.edge_req = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'(ev);
                end else begin
                    it.op        = OP_BIN;
                    it.index     = 8'($urandom);
                    it.edge_req  = 8'($urandom);
                    it.frame_end = ($urandom_range(0, 9) == 0);
                end
                send_item(it, PRED, PRED);
            end
        end
        wait_quiet();

        $display("%0d input transactions sent, %0d of them closing a frame",
                 items_sent, frames_seen);
        $display("%0d band results checked, %0d register writes", bars_checked, reg_writes);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
